// ===== rtl/length_prefixed_record_parser_macros.svh =====
// Assertion macros for the length-prefixed record parser
`ifndef LENGTH_PREFIXED_RECORD_PARSER_MACROS_SVH
`define LENGTH_PREFIXED_RECORD_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, idle while rst_n is low.
`define LPRP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, idle while rst_n is low.
`define LPRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LPRP_ASSERT_IMP(lbl, ante, cons, msg)
`define LPRP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/lprp_pkg.sv =====
// Types and constants shared by the length-prefixed record parser
`timescale 1ns / 1ps

package lprp_pkg;

    localparam int MAGIC_LEN  = 6;
    localparam int AMOUNT_LEN = 8;

    // Configuration register indexes
    localparam logic [1:0] REG_MAGIC_WORD    = 2'd0;
    localparam logic [1:0] REG_FORMAT_MODE   = 2'd1;
    localparam logic [1:0] REG_RETURN_OPCODE = 2'd2;

    localparam logic [7:0] RETURN_OPCODE_RST = 8'd106;

    // Field kinds
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_STR1   = 3'd1;
    localparam logic [2:0] KIND_STR2   = 3'd2;
    localparam logic [2:0] KIND_STR3   = 3'd3;
    localparam logic [2:0] KIND_STR4   = 3'd4;
    localparam logic [2:0] KIND_AMOUNT = 3'd5;

    // Verdicts
    localparam logic [2:0] VERD_PENDING    = 3'd0;
    localparam logic [2:0] VERD_SUCCESS    = 3'd1;
    localparam logic [2:0] VERD_NO_DATA    = 3'd2;
    localparam logic [2:0] VERD_NO_COUNT   = 3'd3;
    localparam logic [2:0] VERD_INCOMPLETE = 3'd4;
    localparam logic [2:0] VERD_STR_OVER   = 3'd5;
    localparam logic [2:0] VERD_NO_LENGTH  = 3'd6;
    localparam logic [2:0] VERD_AMT_TRUNC  = 3'd7;

    typedef struct packed {
        logic [47:0] magic_word;
        logic        format_mode;
        logic [7:0]  return_opcode;
    } cfg_t;

    typedef struct packed {
        logic [7:0] script_byte;
        logic       output_end;
        logic       tx_end;
    } item_t;

    typedef struct packed {
        logic [2:0]         field_kind;
        logic [7:0]         field_byte;
        logic [7:0]         record_number;
        logic signed [63:0] amount_value;
        logic [2:0]         verdict;
        logic               verdict_valid;
    } result_t;

endpackage

// ===== rtl/lprp_cfg.sv =====
// Configuration registers of the record parser
`timescale 1ns / 1ps

module lprp_cfg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [47:0]        cfg_data,
    output lprp_pkg::cfg_t     cfg
);

    lprp_pkg::cfg_t cfg_reg;
    lprp_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                lprp_pkg::REG_MAGIC_WORD:    cfg_next.magic_word    = cfg_data;
                lprp_pkg::REG_FORMAT_MODE:   cfg_next.format_mode   = cfg_data[0];
                lprp_pkg::REG_RETURN_OPCODE: cfg_next.return_opcode = cfg_data[7:0];
                default:                     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic_word    <= '0;
            cfg_reg.format_mode   <= 1'b0;
            cfg_reg.return_opcode <= lprp_pkg::RETURN_OPCODE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== rtl/lprp_parser.sv =====
// Parse state machine: one script byte in, one result out per step
`timescale 1ns / 1ps

module lprp_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  lprp_pkg::item_t     item,
    input  lprp_pkg::cfg_t      cfg,
    output lprp_pkg::result_t   res
);

    `include "length_prefixed_record_parser_macros.svh"

    typedef enum logic [12:0] {
        PH_HDR   = 13'b0000000000001,
        PH_SKIP  = 13'b0000000000010,
        PH_COUNT = 13'b0000000000100,
        PH_LEN1  = 13'b0000000001000,
        PH_STR1  = 13'b0000000010000,
        PH_LEN2  = 13'b0000000100000,
        PH_STR2  = 13'b0000001000000,
        PH_LEN3  = 13'b0000010000000,
        PH_STR3  = 13'b0000100000000,
        PH_AMT   = 13'b0001000000000,
        PH_LEN4  = 13'b0010000000000,
        PH_STR4  = 13'b0100000000000,
        PH_DONE  = 13'b1000000000000
    } phase_t;

    localparam logic [2:0] HDR_LAST = 3'(lprp_pkg::MAGIC_LEN + 1);
    localparam logic [2:0] AMT_LAST = 3'(lprp_pkg::AMOUNT_LEN - 1);

    phase_t      phase_reg, phase_next;
    logic [2:0]  hp_reg, hp_next;
    logic        ok_reg, ok_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  cnt_reg, cnt_next;
    logic [7:0]  str_reg, str_next;
    logic [63:0] acc_reg, acc_next;
    logic [2:0]  seen_reg, seen_next;
    logic        given_reg, given_next;

    logic [7:0]  b;
    logic [7:0]  magic_byte;
    logic [2:0]  done_field;
    logic        rec_done;
    logic        ends;

    assign b    = item.script_byte;
    assign ends = item.output_end | item.tx_end;

    always_comb
    begin
        case (hp_reg)
            3'd2:    magic_byte = cfg.magic_word[47:40];
            3'd3:    magic_byte = cfg.magic_word[39:32];
            3'd4:    magic_byte = cfg.magic_word[31:24];
            3'd5:    magic_byte = cfg.magic_word[23:16];
            3'd6:    magic_byte = cfg.magic_word[15:8];
            3'd7:    magic_byte = cfg.magic_word[7:0];
            default: magic_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        hp_next    = hp_reg;
        ok_next    = ok_reg;
        left_next  = left_reg;
        cnt_next   = cnt_reg;
        str_next   = str_reg;
        acc_next   = acc_reg;
        seen_next  = seen_reg;
        given_next = given_reg;
        done_field = lprp_pkg::KIND_NONE;
        rec_done   = 1'b0;

        res.field_kind    = lprp_pkg::KIND_NONE;
        res.field_byte    = 8'h00;
        res.record_number = 8'h00;
        res.amount_value  = '0;
        res.verdict       = lprp_pkg::VERD_PENDING;

        unique case (phase_reg) inside
            PH_HDR:
            begin
                if (hp_reg == 3'd0)
                    ok_next = (b == cfg.return_opcode);
                else if (hp_reg >= 3'd2 && magic_byte != b)
                    ok_next = 1'b0;
                if (hp_reg >= HDR_LAST)
                    phase_next = ok_next ? PH_COUNT : PH_SKIP;
                else
                    hp_next = hp_reg + 3'd1;
            end
            PH_COUNT:
            begin
                left_next = b;
                cnt_next  = 8'h00;
                if (b == 8'h00)
                begin
                    res.verdict = lprp_pkg::VERD_SUCCESS;
                    given_next  = 1'b1;
                    phase_next  = PH_DONE;
                end
                else
                begin
                    phase_next = PH_LEN1;
                end
            end
            PH_LEN1, PH_LEN2, PH_LEN3, PH_LEN4:
            begin
                str_next = b;
                if (b == 8'h00)
                begin
                    unique case (phase_reg) inside
                        PH_LEN1: done_field = lprp_pkg::KIND_STR1;
                        PH_LEN2: done_field = lprp_pkg::KIND_STR2;
                        PH_LEN3: done_field = lprp_pkg::KIND_STR3;
                        default: done_field = lprp_pkg::KIND_STR4;
                    endcase
                end
                else
                begin
                    unique case (phase_reg) inside
                        PH_LEN1: phase_next = PH_STR1;
                        PH_LEN2: phase_next = PH_STR2;
                        PH_LEN3: phase_next = PH_STR3;
                        default: phase_next = PH_STR4;
                    endcase
                end
            end
            PH_STR1, PH_STR2, PH_STR3, PH_STR4:
            begin
                unique case (phase_reg) inside
                    PH_STR1: res.field_kind = lprp_pkg::KIND_STR1;
                    PH_STR2: res.field_kind = lprp_pkg::KIND_STR2;
                    PH_STR3: res.field_kind = lprp_pkg::KIND_STR3;
                    default: res.field_kind = lprp_pkg::KIND_STR4;
                endcase
                res.field_byte    = b;
                res.record_number = cnt_reg;
                str_next          = str_reg - 8'd1;
                if (str_reg == 8'd1)
                    done_field = res.field_kind;
            end
            PH_AMT:
            begin
                acc_next = acc_reg | (64'(b) << {seen_reg, 3'b000});
                if (seen_reg >= AMT_LAST)
                begin
                    res.field_kind    = lprp_pkg::KIND_AMOUNT;
                    res.record_number = cnt_reg;
                    res.amount_value  = acc_next;
                    acc_next          = '0;
                    seen_next         = 3'd0;
                    done_field        = lprp_pkg::KIND_AMOUNT;
                end
                else
                begin
                    seen_next = seen_reg + 3'd1;
                end
            end
            default: ;
        endcase

        // next field of the record
        case (done_field)
            lprp_pkg::KIND_STR1:   phase_next = PH_LEN2;
            lprp_pkg::KIND_STR2:   phase_next = cfg.format_mode ? PH_AMT : PH_LEN3;
            lprp_pkg::KIND_STR3:   phase_next = PH_AMT;
            lprp_pkg::KIND_STR4:   rec_done   = 1'b1;
            lprp_pkg::KIND_AMOUNT:
            begin
                if (cfg.format_mode)
                    rec_done = 1'b1;
                else
                    phase_next = PH_LEN4;
            end
            default: ;
        endcase

        if (rec_done)
        begin
            left_next = left_reg - 8'd1;
            cnt_next  = cnt_reg + 8'd1;
            if (left_reg == 8'd1)
            begin
                res.verdict = lprp_pkg::VERD_SUCCESS;
                given_next  = 1'b1;
                phase_next  = PH_DONE;
            end
            else
            begin
                phase_next = PH_LEN1;
            end
        end

        // output ended: restart the header search or report the truncation
        if (ends)
        begin
            unique case (phase_next) inside
                PH_HDR, PH_SKIP:
                begin
                    phase_next = PH_HDR;
                    hp_next    = 3'd0;
                    ok_next    = 1'b1;
                end
                PH_COUNT:
                begin
                    res.verdict = lprp_pkg::VERD_NO_COUNT;
                    given_next  = 1'b1;
                    phase_next  = PH_DONE;
                end
                PH_LEN1:
                begin
                    res.verdict = lprp_pkg::VERD_INCOMPLETE;
                    given_next  = 1'b1;
                    phase_next  = PH_DONE;
                end
                PH_STR1, PH_STR2, PH_STR3, PH_STR4:
                begin
                    res.verdict = lprp_pkg::VERD_STR_OVER;
                    given_next  = 1'b1;
                    phase_next  = PH_DONE;
                end
                PH_LEN2, PH_LEN3, PH_LEN4:
                begin
                    res.verdict = lprp_pkg::VERD_NO_LENGTH;
                    given_next  = 1'b1;
                    phase_next  = PH_DONE;
                end
                PH_AMT:
                begin
                    res.verdict = lprp_pkg::VERD_AMT_TRUNC;
                    given_next  = 1'b1;
                    phase_next  = PH_DONE;
                end
                default: ;
            endcase
        end

        if (item.tx_end)
        begin
            if (!given_next)
                res.verdict = lprp_pkg::VERD_NO_DATA;
            phase_next = PH_HDR;
            hp_next    = 3'd0;
            ok_next    = 1'b1;
            left_next  = 8'h00;
            cnt_next   = 8'h00;
            str_next   = 8'h00;
            acc_next   = '0;
            seen_next  = 3'd0;
            given_next = 1'b0;
        end

        res.verdict_valid = (res.verdict != lprp_pkg::VERD_PENDING);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR;
            hp_reg    <= 3'd0;
            ok_reg    <= 1'b1;
            left_reg  <= 8'h00;
            cnt_reg   <= 8'h00;
            str_reg   <= 8'h00;
            acc_reg   <= '0;
            seen_reg  <= 3'd0;
            given_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            hp_reg    <= hp_next;
            ok_reg    <= ok_next;
            left_reg  <= left_next;
            cnt_reg   <= cnt_next;
            str_reg   <= str_next;
            acc_reg   <= acc_next;
            seen_reg  <= seen_next;
            given_reg <= given_next;
        end
    end

    `LPRP_ASSERT_NEXT(a_verdict_parks, step && res.verdict_valid && !item.tx_end, phase_reg == PH_DONE, "verdict given but parser not parked")
    `LPRP_ASSERT_NEXT(a_tx_end_clears, step && item.tx_end, phase_reg == PH_HDR && hp_reg == 3'd0 && !given_reg, "transaction end did not clear state")
    `LPRP_ASSERT_IMP(a_given_done, given_reg, phase_reg == PH_DONE, "verdict flag set outside done phase")
    `LPRP_ASSERT_IMP(a_amount_full, res.field_kind == lprp_pkg::KIND_AMOUNT, seen_reg == AMT_LAST, "amount reported before all bytes seen")

endmodule

// ===== rtl/length_prefixed_record_parser.sv =====
// Top level of the length-prefixed record parser
`timescale 1ns / 1ps

// One script byte per item, one result per item. Items flow through an input
// register and a result register; the parse state is updated between them,
// and a result is captured in the result register after its byte has passed
// the input register. A new byte is taken every cycle unless the result
// register stalls, which it does only when the downstream side holds tready
// low. Configuration writes complete in the cycle they are presented.

module length_prefixed_record_parser
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data,
    // script bytes in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] script_byte
    input  logic        s_tuser,   // [0] output_end
    input  logic        s_tlast,   // tx_end
    // results out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // [7:0] field_byte, [15:8] record_number,
                                   // [79:16] amount_value, [82:80] verdict, rest 0
    output logic [3:0]  m_tuser    // [2:0] field_kind, [3] verdict_valid
);

    lprp_pkg::cfg_t    cfg;
    lprp_pkg::item_t   in_reg;
    lprp_pkg::result_t res;
    lprp_pkg::result_t out_reg;

    logic in_vld_reg, in_vld_next;
    logic out_vld_reg, out_vld_next;
    logic move;

    lprp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lprp_parser u_parser
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (move),
        .item  (in_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign move     = in_vld_reg & (~out_vld_reg | m_tready);
    assign s_tready = ~in_vld_reg | move;

    assign in_vld_next  = (s_tvalid & s_tready) | (in_vld_reg & ~move);
    assign out_vld_next = move | (out_vld_reg & ~m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_reg.script_byte <= s_tdata;
            in_reg.output_end  <= s_tuser;
            in_reg.tx_end      <= s_tlast;
        end
        if (move)
            out_reg <= res;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'b00000, out_reg.verdict, out_reg.amount_value,
                       out_reg.record_number, out_reg.field_byte};
    assign m_tuser  = {out_reg.verdict_valid, out_reg.field_kind};

endmodule
